/* hdl/rotation_matrix_from_angle_axis_core_defines.svh */
// ----------------------------------------------------------------------------
// Rotation matrix core: assertion macros
// Shared concurrent assertion forms used by the core's modules.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_FROM_ANGLE_AXIS_CORE_DEFINES_SVH
`define ROTATION_MATRIX_FROM_ANGLE_AXIS_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMAA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMAA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rmaa_pkg.sv */
// ----------------------------------------------------------------------------
// Rotation matrix core package
// Shared constants, the arctangent table and pipeline payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package rmaa_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 14;
    localparam int MAX_STEPS        = 30;

    // Internal widths: rotation vector in Q4.30, angle in Q6.28 (Q4.28 with headroom).
    localparam int XY_W  = 34;
    localparam int ANG_W = 34;
    localparam int SUM_W = 50;

    localparam logic signed [ANG_W-1:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
    localparam logic signed [XY_W-1:0]  ONE_Q30     = 34'sd1073741824;

    // atan(2^-i) in Q4.28, rounded half up.
    localparam logic signed [ANG_W-1:0] ATAN_Q28 [MAX_STEPS] = '{
        34'sd210828714, 34'sd124459457, 34'sd65760959, 34'sd33381290,
        34'sd16755422,  34'sd8385879,   34'sd4193963,  34'sd2097109,
        34'sd1048571,   34'sd524287,    34'sd262144,   34'sd131072,
        34'sd65536,     34'sd32768,     34'sd16384,    34'sd8192,
        34'sd4096,      34'sd2048,      34'sd1024,     34'sd512,
        34'sd256,       34'sd128,       34'sd64,       34'sd32,
        34'sd16,        34'sd8,         34'sd4,        34'sd2,
        34'sd1,         34'sd1
    };

    typedef enum logic [1:0] {
        AXIS_X   = 2'd0,
        AXIS_Y   = 2'd1,
        AXIS_Z   = 2'd2,
        AXIS_ANY = 2'd3
    } axis_sel_t;

    // Per-item information that rides alongside the CORDIC.
    typedef struct packed {
        logic               neg;
        axis_sel_t          sel;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } rmaa_side_t;

    // CORDIC rotation vector and residual angle.
    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } rmaa_rot_t;

    typedef logic signed [15:0] q_out_t;
    typedef q_out_t [8:0] rmaa_mat_t;

endpackage

`default_nettype wire

/* hdl/rmaa_sample_if.sv */
// ----------------------------------------------------------------------------
// Input channel interface
// Carries one angle and axis description per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmaa_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle_rad;
    logic        [1:0]  axis_select;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;

    modport source (
        output valid, angle_rad, axis_select, axis_x, axis_y, axis_z,
        input  ready
    );

    modport sink (
        input  valid, angle_rad, axis_select, axis_x, axis_y, axis_z,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/rmaa_matrix_if.sv */
// ----------------------------------------------------------------------------
// Output channel interface
// Carries one 3x3 rotation matrix per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmaa_matrix_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        input  ready
    );

    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/rmaa_reduce.sv */
// ----------------------------------------------------------------------------
// Angle reduction
// Two stages: wrap to [-pi, pi], then fold to [-pi/2, pi/2] and seed CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module rmaa_reduce
    import rmaa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] angle,
    input  wire rmaa_side_t         side_in,
    output logic                    out_valid,
    output rmaa_rot_t               rot_out,
    output rmaa_side_t              side_out
);

    logic                    wrap_valid_reg;
    logic signed [ANG_W-1:0] wrap_reg, wrap_next;
    rmaa_side_t              wrap_side_reg;
    logic                    fold_valid_reg;
    rmaa_rot_t               fold_reg, fold_next;
    rmaa_side_t              fold_side_reg, fold_side_next;
    logic signed [ANG_W-1:0] a_ext;

    // Wrap by one turn; the two corrections never both apply.
    always_comb
    begin
        a_ext = {{(ANG_W-32){angle[31]}}, angle};
        priority if (a_ext > PI_Q28)
        begin
            wrap_next = a_ext - TWO_PI_Q28;
        end
        else if (a_ext < -PI_Q28)
        begin
            wrap_next = a_ext + TWO_PI_Q28;
        end
        else
        begin
            wrap_next = a_ext;
        end
    end

    // Fold into the right half plane; the sign flip is applied after CORDIC.
    always_comb
    begin
        fold_side_next     = wrap_side_reg;
        fold_side_next.neg = 1'b0;
        fold_next.x        = GAIN_Q30;
        fold_next.y        = '0;
        priority if (wrap_reg > HALF_PI_Q28)
        begin
            fold_next.z        = wrap_reg - PI_Q28;
            fold_side_next.neg = 1'b1;
        end
        else if (wrap_reg < -HALF_PI_Q28)
        begin
            fold_next.z        = wrap_reg + PI_Q28;
            fold_side_next.neg = 1'b1;
        end
        else
        begin
            fold_next.z = wrap_reg;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_valid_reg <= 1'b0;
            fold_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            wrap_valid_reg <= in_valid;
            fold_valid_reg <= wrap_valid_reg;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wrap_reg      <= wrap_next;
            wrap_side_reg <= side_in;
            fold_reg      <= fold_next;
            fold_side_reg <= fold_side_next;
        end
    end

    assign out_valid = fold_valid_reg;
    assign rot_out   = fold_reg;
    assign side_out  = fold_side_reg;

endmodule

`default_nettype wire

/* hdl/rmaa_cordic_stage.sv */
// ----------------------------------------------------------------------------
// CORDIC stage
// One rotation-mode micro-rotation with its pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmaa_cordic_stage
    import rmaa_pkg::*;
#(
    parameter int                      SHIFT = 0,
    parameter logic signed [ANG_W-1:0] ATAN  = '0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire rmaa_rot_t  rot_in,
    input  wire rmaa_side_t side_in,
    output logic            out_valid,
    output rmaa_rot_t       rot_out,
    output rmaa_side_t      side_out
);

    logic                   valid_reg;
    rmaa_rot_t              rot_reg, rot_next;
    rmaa_side_t             side_reg;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    // Rotate toward zero residual angle.
    always_comb
    begin
        dx = rot_in.y >>> SHIFT;
        dy = rot_in.x >>> SHIFT;
        if (!rot_in.z[ANG_W-1])
        begin
            rot_next.x = rot_in.x - dx;
            rot_next.y = rot_in.y + dy;
            rot_next.z = rot_in.z - ATAN;
        end
        else
        begin
            rot_next.x = rot_in.x + dx;
            rot_next.y = rot_in.y - dy;
            rot_next.z = rot_in.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg  <= rot_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rot_out   = rot_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

/* hdl/rmaa_matrix.sv */
// ----------------------------------------------------------------------------
// Matrix builder
// Five stages: sign fix and axis products, products with t and s, rounding,
// entry sums with axis selection, output rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotation_matrix_from_angle_axis_core_defines.svh"

module rmaa_matrix
    import rmaa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire rmaa_rot_t  rot_in,
    input  wire rmaa_side_t side_in,
    output logic            out_valid,
    output rmaa_mat_t       mat
);

    localparam int PP_W   = 32;
    localparam int PROD_W = PP_W + XY_W;
    localparam int SP_W   = 16 + XY_W;
    localparam int SH2    = 2 * FRAC_BITS;
    localparam int SH1    = FRAC_BITS;
    localparam int SHO    = 30 - FRAC_BITS;
    localparam logic [PROD_W-1:0] BIAS2 = (PROD_W'(1) << SH2) >> 1;
    localparam logic [SP_W-1:0]   BIAS1 = (SP_W'(1) << SH1) >> 1;
    localparam logic [SUM_W-1:0]  BIASO = (SUM_W'(1) << SHO) >> 1;
    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(32768);
    localparam logic signed [15:0] ONE_OUT =
        (FRAC_BITS >= 15) ? 16'sd32767 : 16'(1 << FRAC_BITS);

    // Stage 1: signed sine and cosine, t = 1 - c, axis pair products.
    logic                   v1_reg;
    axis_sel_t              sel1_reg;
    logic signed [XY_W-1:0] c1_reg, s1_reg, t1_reg;
    logic signed [XY_W-1:0] c1_next, s1_next;
    logic signed [PP_W-1:0] pp1_reg [6];
    logic signed [15:0]     ax1_reg, ay1_reg, az1_reg;

    // Stage 2: raw products.
    logic                     v2_reg;
    axis_sel_t                sel2_reg;
    logic signed [XY_W-1:0]   c2_reg, s2_reg;
    logic signed [PROD_W-1:0] tp2_reg [6];
    logic signed [SP_W-1:0]   sp2_reg [3];

    // Stage 3: terms rounded to Q30.
    logic                   v3_reg;
    axis_sel_t              sel3_reg;
    logic signed [XY_W-1:0] c3_reg, s3_reg;
    logic signed [SUM_W-1:0] tq3_reg [6];
    logic signed [SUM_W-1:0] sq3_reg [3];
    logic signed [PROD_W-1:0] tr_full [6];
    logic signed [SP_W-1:0]   sr_full [3];

    // Stage 4: entries in Q30.
    logic                    v4_reg;
    axis_sel_t               sel4_reg;
    logic signed [SUM_W-1:0] m4_reg [9];
    logic signed [SUM_W-1:0] m4_next [9];

    // Stage 5: output entries.
    logic                    v5_reg;
    axis_sel_t               sel5_reg;
    rmaa_mat_t               m5_reg, m5_next;
    logic signed [SUM_W-1:0] ro [9];

    always_comb
    begin
        c1_next = side_in.neg ? -rot_in.x : rot_in.x;
        s1_next = side_in.neg ? -rot_in.y : rot_in.y;
    end

    // Rounding of the product terms; index order xx yy zz xy xz yz / xs ys zs.
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            tr_full[k] = (tp2_reg[k] + $signed(BIAS2)) >>> SH2;
        end
        for (int k = 0; k < 3; k++)
        begin
            sr_full[k] = (sp2_reg[k] + $signed(BIAS1)) >>> SH1;
        end
    end

    // Entry sums, selected by axis mode.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            m4_next[k] = '0;
        end
        unique case (sel3_reg)
            AXIS_X:
            begin
                m4_next[0] = SUM_W'(ONE_Q30);
                m4_next[4] = SUM_W'(c3_reg);
                m4_next[5] = SUM_W'(s3_reg);
                m4_next[7] = -SUM_W'(s3_reg);
                m4_next[8] = SUM_W'(c3_reg);
            end
            AXIS_Y:
            begin
                m4_next[0] = SUM_W'(c3_reg);
                m4_next[2] = -SUM_W'(s3_reg);
                m4_next[4] = SUM_W'(ONE_Q30);
                m4_next[6] = SUM_W'(s3_reg);
                m4_next[8] = SUM_W'(c3_reg);
            end
            AXIS_Z:
            begin
                m4_next[0] = SUM_W'(c3_reg);
                m4_next[1] = SUM_W'(s3_reg);
                m4_next[3] = -SUM_W'(s3_reg);
                m4_next[4] = SUM_W'(c3_reg);
                m4_next[8] = SUM_W'(ONE_Q30);
            end
            AXIS_ANY:
            begin
                m4_next[0] = tq3_reg[0] + SUM_W'(c3_reg);
                m4_next[1] = tq3_reg[3] + sq3_reg[2];
                m4_next[2] = tq3_reg[4] - sq3_reg[1];
                m4_next[3] = tq3_reg[3] - sq3_reg[2];
                m4_next[4] = tq3_reg[1] + SUM_W'(c3_reg);
                m4_next[5] = tq3_reg[5] + sq3_reg[0];
                m4_next[6] = tq3_reg[4] + sq3_reg[1];
                m4_next[7] = tq3_reg[5] - sq3_reg[0];
                m4_next[8] = tq3_reg[2] + SUM_W'(c3_reg);
            end
            default:
            begin
                m4_next[0] = '0;
            end
        endcase
    end

    // Output rounding and saturation.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            ro[k] = (m4_reg[k] + $signed(BIASO)) >>> SHO;
            if (ro[k] > OUT_MAX)
            begin
                m5_next[k] = 16'sh7FFF;
            end
            else if (ro[k] < OUT_MIN)
            begin
                m5_next[k] = 16'sh8000;
            end
            else
            begin
                m5_next[k] = ro[k][15:0];
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel1_reg   <= side_in.sel;
            c1_reg     <= c1_next;
            s1_reg     <= s1_next;
            t1_reg     <= ONE_Q30 - c1_next;
            ax1_reg    <= side_in.ax;
            ay1_reg    <= side_in.ay;
            az1_reg    <= side_in.az;
            pp1_reg[0] <= side_in.ax * side_in.ax;
            pp1_reg[1] <= side_in.ay * side_in.ay;
            pp1_reg[2] <= side_in.az * side_in.az;
            pp1_reg[3] <= side_in.ax * side_in.ay;
            pp1_reg[4] <= side_in.ax * side_in.az;
            pp1_reg[5] <= side_in.ay * side_in.az;

            sel2_reg <= sel1_reg;
            c2_reg   <= c1_reg;
            s2_reg   <= s1_reg;
            for (int k = 0; k < 6; k++)
            begin
                tp2_reg[k] <= pp1_reg[k] * t1_reg;
            end
            sp2_reg[0] <= ax1_reg * s1_reg;
            sp2_reg[1] <= ay1_reg * s1_reg;
            sp2_reg[2] <= az1_reg * s1_reg;

            sel3_reg <= sel2_reg;
            c3_reg   <= c2_reg;
            s3_reg   <= s2_reg;
            for (int k = 0; k < 6; k++)
            begin
                tq3_reg[k] <= tr_full[k][SUM_W-1:0];
            end
            for (int k = 0; k < 3; k++)
            begin
                sq3_reg[k] <= SUM_W'(sr_full[k]);
            end

            sel4_reg <= sel3_reg;
            m4_reg   <= m4_next;

            sel5_reg <= sel4_reg;
            m5_reg   <= m5_next;
        end
    end

    assign out_valid = v5_reg;
    assign mat       = m5_reg;

    `RMAA_ASSERT_NOW(a_x_axis_fixed, clk, rst_n,
        v5_reg && (sel5_reg == AXIS_X),
        (m5_reg[0] == ONE_OUT) && (m5_reg[1] == 16'sd0) && (m5_reg[3] == 16'sd0),
        "X-axis matrix lost its fixed row or column")
    `RMAA_ASSERT_NOW(a_z_axis_fixed, clk, rst_n,
        v5_reg && (sel5_reg == AXIS_Z),
        (m5_reg[8] == ONE_OUT) && (m5_reg[2] == 16'sd0) && (m5_reg[6] == 16'sd0),
        "Z-axis matrix lost its fixed row or column")

endmodule

`default_nettype wire

/* hdl/rotation_matrix_from_angle_axis_core.sv */
// ----------------------------------------------------------------------------
// Rotation matrix from angle and axis
// Top level: angle reduction, pipelined CORDIC and the matrix builder.
// ----------------------------------------------------------------------------
// The core takes one angle (Q4.28 radians) with a principal axis or an
// arbitrary axis vector per transaction and returns the 3x3 rotation matrix,
// entries rounded and saturated to 16 bits. It accepts a new transaction every
// cycle unless the output stalls. Angle reduction stages, one register stage per
// CORDIC micro-rotation (at most 30) and the multiplier and rounding stages of
// the matrix builder make up the pipeline. All stages advance together; while a
// finished matrix waits on the output, the pipeline holds and the input is not
// ready, and empty stages are filled whenever the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotation_matrix_from_angle_axis_core_defines.svh"

module rotation_matrix_from_angle_axis_core
    import rmaa_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    rmaa_sample_if.sink   sample,
    rmaa_matrix_if.source matrix
);

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    logic       pipe_en;
    rmaa_side_t side_in;
    logic       valid_chain [STEPS+1];
    rmaa_rot_t  rot_chain   [STEPS+1];
    rmaa_side_t side_chain  [STEPS+1];
    rmaa_mat_t  mat;

    // The whole pipeline moves unless a finished matrix is held on the output.
    assign pipe_en      = !matrix.valid || matrix.ready;
    assign sample.ready = pipe_en;

    always_comb
    begin
        side_in     = '0;
        side_in.sel = axis_sel_t'(sample.axis_select);
        side_in.ax  = sample.axis_x;
        side_in.ay  = sample.axis_y;
        side_in.az  = sample.axis_z;
    end

    rmaa_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (sample.valid),
        .angle     (sample.angle_rad),
        .side_in   (side_in),
        .out_valid (valid_chain[0]),
        .rot_out   (rot_chain[0]),
        .side_out  (side_chain[0])
    );

    // One register stage per micro-rotation.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cordic
        rmaa_cordic_stage #(
            .SHIFT (i),
            .ATAN  (ATAN_Q28[i])
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (valid_chain[i]),
            .rot_in    (rot_chain[i]),
            .side_in   (side_chain[i]),
            .out_valid (valid_chain[i+1]),
            .rot_out   (rot_chain[i+1]),
            .side_out  (side_chain[i+1])
        );
    end

    rmaa_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (valid_chain[STEPS]),
        .rot_in    (rot_chain[STEPS]),
        .side_in   (side_chain[STEPS]),
        .out_valid (matrix.valid),
        .mat       (mat)
    );

    assign matrix.m00 = mat[0];
    assign matrix.m01 = mat[1];
    assign matrix.m02 = mat[2];
    assign matrix.m10 = mat[3];
    assign matrix.m11 = mat[4];
    assign matrix.m12 = mat[5];
    assign matrix.m20 = mat[6];
    assign matrix.m21 = mat[7];
    assign matrix.m22 = mat[8];

    `RMAA_ASSERT_NOW(a_ready_follows_output, clk, rst_n, 1'b1,
        sample.ready == (!matrix.valid || matrix.ready),
        "Input ready does not follow the output register state")
    `RMAA_ASSERT_NEXT(a_stall_freezes_cordic, clk, rst_n, !pipe_en,
        $stable(valid_chain[STEPS]) && $stable(rot_chain[STEPS]),
        "CORDIC output changed while the pipeline was stalled")

endmodule

`default_nettype wire
